>>> rtl/nec_ir_frame_receiver_core_assert.svh
// Assertion macros shared by the receiver RTL.
// IMP checks an implication in the same cycle, NEXT checks it in the next cycle.
`ifndef NEC_IR_FRAME_RECEIVER_CORE_ASSERT_SVH
`define NEC_IR_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NECIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define NECIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define NECIR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NECIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/necir_pkg.sv
`timescale 1ns / 1ps

package necir_pkg;

    localparam int DUR_W   = 16;
    localparam int WORD_W  = 32;
    localparam int WALK_AW = 7;

    // The walk reads entries 1 through 66: header mark, header space and 32 bit pairs.
    localparam logic [WALK_AW-1:0] WALK_FIRST = 7'd1;
    localparam logic [WALK_AW-1:0] WALK_LAST  = 7'd66;
    localparam logic [WALK_AW-1:0] HDR_MARK_IX  = 7'd1;
    localparam logic [WALK_AW-1:0] HDR_SPACE_IX = 7'd2;
    localparam logic [WALK_AW-1:0] RPT_MARK_IX  = 7'd3;

    localparam int REPEAT_ENTRIES = 4;
    localparam int FRAME_ENTRIES  = 68;

    localparam logic [DUR_W-1:0] HDR_MARK_LO  = 16'd136;
    localparam logic [DUR_W-1:0] HDR_MARK_HI  = 16'd9327;
    localparam logic [DUR_W-1:0] HDR_SPACE_LO = 16'd66;
    localparam logic [DUR_W-1:0] HDR_SPACE_HI = 16'd4510;
    localparam logic [DUR_W-1:0] RPT_SPACE_LO = 16'd32;
    localparam logic [DUR_W-1:0] RPT_SPACE_HI = 16'd2203;
    localparam logic [DUR_W-1:0] BIT_MARK_LO  = 16'd9;
    localparam logic [DUR_W-1:0] BIT_MARK_HI  = 16'd676;
    localparam logic [DUR_W-1:0] ONE_SPACE_LO = 16'd22;
    localparam logic [DUR_W-1:0] ONE_SPACE_HI = 16'd1537;
    localparam logic [DUR_W-1:0] ZERO_SPACE_LO = 16'd6;
    localparam logic [DUR_W-1:0] ZERO_SPACE_HI = 16'd471;

    localparam logic [DUR_W-1:0]  TICK_MAX     = 16'hFFFF;
    localparam logic [DUR_W-1:0]  IDLE_RESET   = 16'd100;
    localparam logic [WORD_W-1:0] REPEAT_WORD  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MARK,
        PH_SPACE,
        PH_CLOSED
    } t_phase;

    typedef enum logic {
        TS_CAPTURE,
        TS_WALK
    } t_top_state;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_RUN,
        WS_LAST,
        WS_DONE
    } t_walk_state;

    typedef enum logic [1:0] {
        KIND_FRAME  = 2'd0,
        KIND_REPEAT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        logic start;
        logic take;
        logic cnt_four;
        logic cnt_enough;
    } t_walk_ctl;

    typedef struct packed {
        logic              done;
        t_kind             kind;
        logic [WORD_W-1:0] word;
    } t_walk_res;

    function automatic logic in_window(input logic [DUR_W-1:0] d,
                                       input logic [DUR_W-1:0] lo,
                                       input logic [DUR_W-1:0] hi);
        return (d >= lo) && (d <= hi);
    endfunction

endpackage

>>> rtl/necir_if.sv
`timescale 1ns / 1ps

interface necir_pin_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source(output valid, output pin_level, input ready);
    modport sink(input valid, input pin_level, output ready);
endinterface

interface necir_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] frame_word;
    logic [7:0]  address;
    logic [7:0]  command;

    modport source(output valid, output result_kind, output frame_word, output address,
                   output command, input ready);
    modport sink(input valid, input result_kind, input frame_word, input address,
                 input command, output ready);
endinterface

interface necir_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/nec_ir_frame_receiver_core.sv
`timescale 1ns / 1ps
// One pin sample is taken per cycle while capturing; a sample that does not close a frame
// gives no result. A closing sample starts a walk over the duration memory, one read per
// cycle for entries 1 to 66, and the result is registered when the walk is done.
// The pin channel is not ready during the walk, so no new sample is taken until the result is registered.
// Synchronous active-low reset clears control state and sets idle_ticks to 100.

`include "nec_ir_frame_receiver_core_assert.svh"

module nec_ir_frame_receiver_core #(
    parameter int MAX_ENTRIES = 70
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    necir_cfg_if.sink     i_cfg,
    necir_pin_if.sink     i_pin,
    necir_res_if.source   o_res
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    necir_pkg::t_top_state r_top_state, n_top_state;
    necir_pkg::t_phase     r_phase, n_phase, eff_phase;

    logic [necir_pkg::DUR_W-1:0] r_idle_ticks;
    logic [necir_pkg::DUR_W-1:0] r_tick, n_tick, tick_inc;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_cnt_four, r_cnt_enough;
    logic                        r_start;

    logic                        pin_xfer;
    logic                        cap_close;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [necir_pkg::DUR_W-1:0] r_mem [MAX_ENTRIES];
    logic [necir_pkg::DUR_W-1:0] r_rd_data;

    necir_pkg::t_walk_ctl          walk_ctl;
    necir_pkg::t_walk_res          walk_res;
    logic                          walk_rd_en;
    logic [necir_pkg::WALK_AW-1:0] walk_rd_addr;
    logic                          out_take;

    logic                          r_out_valid;
    necir_pkg::t_kind              r_kind;
    logic [necir_pkg::WORD_W-1:0]  r_word;
    logic [7:0]                    r_addr;
    logic [7:0]                    r_cmd;

    assign i_cfg.ready = 1'b1;
    assign pin_xfer    = i_pin.valid && i_pin.ready;
    assign out_take    = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= necir_pkg::IDLE_RESET;
        end else if (i_cfg.valid) begin
            r_idle_ticks <= i_cfg.data;
        end
    end

    // Capture: run lengths of marks and spaces go into the duration memory.
    always_comb begin
        tick_inc  = (r_tick == necir_pkg::TICK_MAX) ? r_tick : r_tick + 16'd1;
        eff_phase = (r_count >= CW'(MAX_ENTRIES)) ? necir_pkg::PH_CLOSED : r_phase;
        n_tick    = r_tick;
        n_count   = r_count;
        n_phase   = r_phase;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        cap_close = 1'b0;
        if (pin_xfer) begin
            n_tick = tick_inc;
            unique case (eff_phase)
                necir_pkg::PH_IDLE: begin
                    if (!i_pin.pin_level) begin
                        n_tick = '0;
                        if (tick_inc >= r_idle_ticks) begin
                            // Entry 0 keeps the idle run that preceded the header.
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            n_count   = CW'(1);
                            n_phase   = necir_pkg::PH_MARK;
                        end
                    end
                end
                necir_pkg::PH_MARK: begin
                    if (i_pin.pin_level) begin
                        mem_we  = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                        n_tick  = '0;
                        n_phase = necir_pkg::PH_SPACE;
                    end
                end
                necir_pkg::PH_SPACE: begin
                    if (!i_pin.pin_level) begin
                        mem_we  = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                        n_tick  = '0;
                        n_phase = necir_pkg::PH_MARK;
                    end else if (tick_inc > r_idle_ticks) begin
                        cap_close = 1'b1;
                    end
                end
                necir_pkg::PH_CLOSED: begin
                    cap_close = 1'b1;
                    if (!i_pin.pin_level) begin
                        n_tick = '0;
                    end
                end
                default: begin
                    n_phase = necir_pkg::PH_IDLE;
                end
            endcase
            if (cap_close) begin
                n_phase = necir_pkg::PH_IDLE;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= necir_pkg::PH_IDLE;
            r_tick  <= '0;
            r_count <= '0;
            r_start <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_count <= n_count;
            r_start <= pin_xfer && cap_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pin_xfer && cap_close) begin
            r_cnt_four   <= (r_count == CW'(necir_pkg::REPEAT_ENTRIES));
            r_cnt_enough <= (r_count >= CW'(necir_pkg::FRAME_ENTRIES));
        end
    end

    // Duration memory. Writes come only from capture and reads only from the
    // walk, and capture is stalled while the walk runs, so they never overlap.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= tick_inc;
        end
        if (walk_rd_en) begin
            r_rd_data <= r_mem[AW'(walk_rd_addr)];
        end
    end

    // Top control: next state.
    always_comb begin
        n_top_state = r_top_state;
        unique case (r_top_state)
            necir_pkg::TS_CAPTURE: begin
                if (pin_xfer && cap_close) begin
                    n_top_state = necir_pkg::TS_WALK;
                end
            end
            necir_pkg::TS_WALK: begin
                if (walk_res.done && out_take) begin
                    n_top_state = necir_pkg::TS_CAPTURE;
                end
            end
            default: begin
                n_top_state = necir_pkg::TS_CAPTURE;
            end
        endcase
    end

    // Top control: outputs.
    always_comb begin
        i_pin.ready         = (r_top_state == necir_pkg::TS_CAPTURE);
        walk_ctl.start      = r_start;
        walk_ctl.take       = out_take;
        walk_ctl.cnt_four   = r_cnt_four;
        walk_ctl.cnt_enough = r_cnt_enough;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_state <= necir_pkg::TS_CAPTURE;
        end else begin
            r_top_state <= n_top_state;
        end
    end

    necir_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (walk_ctl),
        .i_rd_data (r_rd_data),
        .o_rd_en   (walk_rd_en),
        .o_rd_addr (walk_rd_addr),
        .o_res     (walk_res)
    );

    // Result register; it holds until the downstream transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (walk_res.done && out_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_res.done && out_take) begin
            r_kind <= walk_res.kind;
            r_word <= walk_res.word;
            if (walk_res.kind == necir_pkg::KIND_FRAME) begin
                r_addr <= walk_res.word[7:0];
                r_cmd  <= walk_res.word[23:16];
            end else begin
                r_addr <= '0;
                r_cmd  <= '0;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_kind;
    assign o_res.frame_word  = r_word;
    assign o_res.address     = r_addr;
    assign o_res.command     = r_cmd;

    `NECIR_ASSERT_IMP(a_no_write_in_walk, i_clk, i_rst_n, r_top_state == necir_pkg::TS_WALK, !mem_we)
    `NECIR_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ENTRIES))
    `NECIR_ASSERT_NEXT(a_close_starts_walk, i_clk, i_rst_n, pin_xfer && cap_close, r_start && (r_top_state == necir_pkg::TS_WALK))
    `NECIR_ASSERT_IMP(a_done_only_in_walk, i_clk, i_rst_n, walk_res.done, r_top_state == necir_pkg::TS_WALK)
    `NECIR_ASSERT_IMP(a_fields_zero_unless_frame, i_clk, i_rst_n, r_out_valid && (r_kind != necir_pkg::KIND_FRAME), (r_addr == 8'd0) && (r_cmd == 8'd0))

endmodule

>>> rtl/necir_walk.sv
`timescale 1ns / 1ps

module necir_walk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  necir_pkg::t_walk_ctl              i_ctl,
    input  logic [necir_pkg::DUR_W-1:0]       i_rd_data,
    output logic                              o_rd_en,
    output logic [necir_pkg::WALK_AW-1:0]     o_rd_addr,
    output necir_pkg::t_walk_res              o_res
);

    necir_pkg::t_walk_state r_state;
    necir_pkg::t_walk_state n_state;

    logic [necir_pkg::WALK_AW-1:0] r_addr;
    logic                          r_chk_vld;
    logic [necir_pkg::WALK_AW-1:0] r_chk_addr;
    logic                          r_hdr_ok, n_hdr_ok;
    logic                          r_rpt_sp, n_rpt_sp;
    logic                          r_rpt_mk, n_rpt_mk;
    logic                          r_fail, n_fail;
    logic [necir_pkg::WORD_W-1:0]  r_word, n_word;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            necir_pkg::WS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = necir_pkg::WS_RUN;
                end
            end
            necir_pkg::WS_RUN: begin
                if (r_addr == necir_pkg::WALK_LAST) begin
                    n_state = necir_pkg::WS_LAST;
                end
            end
            necir_pkg::WS_LAST: begin
                n_state = necir_pkg::WS_DONE;
            end
            necir_pkg::WS_DONE: begin
                if (i_ctl.take) begin
                    n_state = necir_pkg::WS_IDLE;
                end
            end
            default: begin
                n_state = necir_pkg::WS_IDLE;
            end
        endcase
    end

    // State outputs and the final verdict.
    always_comb begin
        o_rd_en   = (r_state == necir_pkg::WS_RUN);
        o_rd_addr = r_addr;
        o_res.done = (r_state == necir_pkg::WS_DONE);
        priority if (!r_hdr_ok) begin
            o_res.kind = necir_pkg::KIND_REJECT;
            o_res.word = '0;
        end else if (i_ctl.cnt_four && r_rpt_sp && r_rpt_mk) begin
            o_res.kind = necir_pkg::KIND_REPEAT;
            o_res.word = necir_pkg::REPEAT_WORD;
        end else if (!i_ctl.cnt_enough || r_fail || (r_word[31:24] != ~r_word[23:16])) begin
            o_res.kind = necir_pkg::KIND_REJECT;
            o_res.word = '0;
        end else begin
            o_res.kind = necir_pkg::KIND_FRAME;
            o_res.word = r_word;
        end
    end

    // Check of the entry whose read data arrives this cycle. Odd entries from
    // three on are bit marks, even entries from four on are bit spaces.
    always_comb begin
        n_hdr_ok = r_hdr_ok;
        n_rpt_sp = r_rpt_sp;
        n_rpt_mk = r_rpt_mk;
        n_fail   = r_fail;
        n_word   = r_word;
        if (r_chk_vld) begin
            priority if (r_chk_addr == necir_pkg::HDR_MARK_IX) begin
                n_hdr_ok = necir_pkg::in_window(i_rd_data, necir_pkg::HDR_MARK_LO,
                                                necir_pkg::HDR_MARK_HI);
            end else if (r_chk_addr == necir_pkg::HDR_SPACE_IX) begin
                n_rpt_sp = necir_pkg::in_window(i_rd_data, necir_pkg::RPT_SPACE_LO,
                                                necir_pkg::RPT_SPACE_HI);
                if (!necir_pkg::in_window(i_rd_data, necir_pkg::HDR_SPACE_LO,
                                          necir_pkg::HDR_SPACE_HI)) begin
                    n_fail = 1'b1;
                end
            end else if (r_chk_addr[0]) begin
                if (r_chk_addr == necir_pkg::RPT_MARK_IX) begin
                    n_rpt_mk = necir_pkg::in_window(i_rd_data, necir_pkg::BIT_MARK_LO,
                                                    necir_pkg::BIT_MARK_HI);
                end
                if (!necir_pkg::in_window(i_rd_data, necir_pkg::BIT_MARK_LO,
                                          necir_pkg::BIT_MARK_HI)) begin
                    n_fail = 1'b1;
                end
            end else begin
                priority if (necir_pkg::in_window(i_rd_data, necir_pkg::ONE_SPACE_LO,
                                                  necir_pkg::ONE_SPACE_HI)) begin
                    n_word = {1'b1, r_word[necir_pkg::WORD_W-1:1]};
                end else if (necir_pkg::in_window(i_rd_data, necir_pkg::ZERO_SPACE_LO,
                                                  necir_pkg::ZERO_SPACE_HI)) begin
                    n_word = {1'b0, r_word[necir_pkg::WORD_W-1:1]};
                end else begin
                    n_word = r_word;
                    n_fail = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= necir_pkg::WS_IDLE;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == necir_pkg::WS_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= r_addr;
        if ((r_state == necir_pkg::WS_IDLE) && i_ctl.start) begin
            r_addr   <= necir_pkg::WALK_FIRST;
            r_hdr_ok <= 1'b0;
            r_rpt_sp <= 1'b0;
            r_rpt_mk <= 1'b0;
            r_fail   <= 1'b0;
            r_word   <= '0;
        end else begin
            if (r_state == necir_pkg::WS_RUN) begin
                r_addr <= r_addr + 7'd1;
            end
            r_hdr_ok <= n_hdr_ok;
            r_rpt_sp <= n_rpt_sp;
            r_rpt_mk <= n_rpt_mk;
            r_fail   <= n_fail;
            r_word   <= n_word;
        end
    end

endmodule
